// ===== design/vcom_flicker_minimum_search_defines.svh =====
// Assertion macros shared by the VCOM flicker minimum search modules.
`ifndef VCOM_FLICKER_MINIMUM_SEARCH_DEFINES_SVH
`define VCOM_FLICKER_MINIMUM_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define VFMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vfms assertion failed");

// Next-cycle implication, disabled while reset is low.
`define VFMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vfms assertion failed");

`endif

// ===== design/vfms_pkg.sv =====
// Types and constants shared by the VCOM flicker minimum search modules.
`timescale 1ns / 1ps

package vfms_pkg;

    // Field widths.
    localparam int SETTING_W = 8;
    localparam int FLICKER_W = 12;
    localparam int CFG_IDX_W = 2;

    // Configuration reset values.
    localparam logic [SETTING_W-1:0] LOW_LIMIT_RST  = '0;
    localparam logic [SETTING_W-1:0] HIGH_LIMIT_RST = '1;
    localparam logic [SETTING_W-1:0] STOP_SPAN_RST  = SETTING_W'(8);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_LIMIT  = 2'd0,
        CFG_HIGH_LIMIT = 2'd1,
        CFG_STOP_SPAN  = 2'd2
    } t_cfg_idx;

    // Input item function codes.
    typedef enum logic {
        FN_START   = 1'b0,
        FN_READING = 1'b1
    } t_func;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_MEASURE = 2'd0,
        ST_DONE    = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    // Search phase: idle, or which reading is awaited.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LOW    = 3'd1,
        PH_CENTER = 3'd2,
        PH_HIGH   = 3'd3,
        PH_LC     = 3'd4,
        PH_RC     = 3'd5,
        PH_MID    = 3'd6
    } t_phase;

    // Input item.
    typedef struct packed {
        t_func                func;
        logic [FLICKER_W-1:0] flicker_value;
    } t_vfms_in;

    // Result item.
    typedef struct packed {
        logic [SETTING_W-1:0] vcom_setting;
        t_status              status;
    } t_vfms_out;

    // Configuration registers.
    typedef struct packed {
        logic [SETTING_W-1:0] low_limit;
        logic [SETTING_W-1:0] high_limit;
        logic [SETTING_W-1:0] stop_span;
    } t_cfg;

    // Bracket state of the search.
    typedef struct packed {
        t_phase               phase;
        logic [SETTING_W-1:0] set_low;
        logic [SETTING_W-1:0] set_ctr;
        logic [SETTING_W-1:0] set_high;
        logic [FLICKER_W-1:0] flk_low;
        logic [FLICKER_W-1:0] flk_ctr;
        logic [FLICKER_W-1:0] flk_high;
        logic [FLICKER_W-1:0] flk_lc;
    } t_search_state;

endpackage

// ===== design/vcom_flicker_minimum_search.sv =====
// Top level of the VCOM flicker minimum search sequencer.
`timescale 1ns / 1ps

// Every accepted item (a start or a flicker reading) produces exactly one result.
// When the output buffer is empty, the result appears on the output in the cycle after
// the input transfer. The whole bracket update, including the first narrowing and the
// following halving step, is combinational between the bracket state and output
// registers, so one item is accepted per cycle unless the input stalls. Results wait
// in a two-entry output buffer, and the input stalls only while both entries hold
// untaken results. The low and high limits are read only by a start item. The stop
// span is read at every halving step, so a new value also applies to a running search.

module vcom_flicker_minimum_search
    import vfms_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_vfms_in             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_vfms_out            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SETTING_W-1:0] i_cfg_data
);

`include "vcom_flicker_minimum_search_defines.svh"

    t_cfg          r_cfg;
    t_search_state r_state;
    t_search_state n_state;
    t_vfms_out     step_result;
    logic          accept;
    logic          buf_full;

    assign accept     = i_in_valid && !buf_full;
    assign o_in_stall = buf_full;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_limit  <= LOW_LIMIT_RST;
            r_cfg.high_limit <= HIGH_LIMIT_RST;
            r_cfg.stop_span  <= STOP_SPAN_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LOW_LIMIT:  r_cfg.low_limit  <= i_cfg_data;
                CFG_HIGH_LIMIT: r_cfg.high_limit <= i_cfg_data;
                CFG_STOP_SPAN:  r_cfg.stop_span  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Bracket update for the item at the input.
    vfms_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (i_in_data),
        .o_state  (n_state),
        .o_result (step_result)
    );

    // Bracket state register, advanced on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Output register and skid stage.
    vfms_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_data      (step_result),
        .o_full      (buf_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // A start always leads to a request for the low reading.
    `VFMS_ASSERT_NEXT(a_start_to_low, i_clk, i_rst_n,
        accept && i_in_data.func == FN_START, r_state.phase == PH_LOW)
    // A reading while idle leaves the bracket untouched.
    `VFMS_ASSERT_NEXT(a_idle_reading_kept, i_clk, i_rst_n,
        accept && i_in_data.func == FN_READING && r_state.phase == PH_IDLE,
        $stable(r_state))
    // The low reading is followed by a request for the center reading.
    `VFMS_ASSERT_NEXT(a_low_to_center, i_clk, i_rst_n,
        accept && i_in_data.func == FN_READING && r_state.phase == PH_LOW,
        r_state.phase == PH_CENTER)

endmodule

// ===== design/vfms_step.sv =====
// Next-state and result logic for one item of the VCOM flicker search.
`timescale 1ns / 1ps

module vfms_step
    import vfms_pkg::*;
(
    input  t_search_state i_state,
    input  t_cfg          i_cfg,
    input  t_vfms_in      i_item,
    output t_search_state o_state,
    output t_vfms_out     o_result
);

    // Floor of the mean of two settings.
    function automatic logic [SETTING_W-1:0] midpoint(
        input logic [SETTING_W-1:0] a,
        input logic [SETTING_W-1:0] b
    );
        logic [SETTING_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[SETTING_W:1];
    endfunction

    function automatic logic [SETTING_W-1:0] absdiff_set(
        input logic [SETTING_W-1:0] a,
        input logic [SETTING_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [FLICKER_W-1:0] absdiff_flk(
        input logic [FLICKER_W-1:0] a,
        input logic [FLICKER_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    t_search_state narrowed;
    t_search_state cont_in;
    t_search_state cont_out;
    t_vfms_out     cont_res;

    // First narrowing after the two inner readings: keep the half with the smaller one, the upper half on a tie.
    always_comb begin
        narrowed = i_state;
        if (i_state.flk_lc < i_item.flicker_value) begin
            narrowed.set_high = i_state.set_ctr;
            narrowed.flk_high = i_state.flk_ctr;
            narrowed.flk_ctr  = i_state.flk_lc;
        end else begin
            narrowed.set_low = i_state.set_ctr;
            narrowed.flk_low = i_state.flk_ctr;
            narrowed.flk_ctr = i_item.flicker_value;
        end
        narrowed.set_ctr = midpoint(narrowed.set_low, narrowed.set_high);
    end

    // Bracket that feeds the halving step.
    always_comb begin
        cont_in = i_state;
        cont_in.flk_ctr = i_item.flicker_value;
        if (i_state.phase == PH_RC) begin
            cont_in = narrowed;
        end
    end

    // Halving step: move toward the side whose neighboring readings differ less, until within the stop span.
    always_comb begin
        cont_out = cont_in;
        if (absdiff_set(cont_in.set_high, cont_in.set_low) > i_cfg.stop_span) begin
            if (absdiff_flk(cont_in.flk_low, cont_in.flk_ctr) <
                absdiff_flk(cont_in.flk_ctr, cont_in.flk_high)) begin
                cont_out.set_high = cont_in.set_ctr;
                cont_out.flk_high = cont_in.flk_ctr;
            end else begin
                cont_out.set_low = cont_in.set_ctr;
                cont_out.flk_low = cont_in.flk_ctr;
            end
            cont_out.set_ctr = midpoint(cont_out.set_low, cont_out.set_high);
            cont_out.phase   = PH_MID;
            cont_res.vcom_setting = cont_out.set_ctr;
            cont_res.status       = ST_MEASURE;
        end else begin
            cont_out.phase        = PH_IDLE;
            cont_res.vcom_setting = cont_in.set_ctr;
            cont_res.status       = ST_DONE;
        end
    end

    // Dispatch on the item function and the awaited reading.
    always_comb begin
        o_state = i_state;
        o_result.vcom_setting = '0;
        o_result.status       = ST_MEASURE;
        if (i_item.func == FN_START) begin
            o_state.set_low  = i_cfg.low_limit;
            o_state.set_high = i_cfg.high_limit;
            o_state.set_ctr  = midpoint(i_cfg.low_limit, i_cfg.high_limit);
            o_state.phase    = PH_LOW;
            o_result.vcom_setting = i_cfg.low_limit;
        end else begin
            case (i_state.phase)
                PH_LOW: begin
                    o_state.flk_low = i_item.flicker_value;
                    o_state.phase   = PH_CENTER;
                    o_result.vcom_setting = i_state.set_ctr;
                end
                PH_CENTER: begin
                    o_state.flk_ctr = i_item.flicker_value;
                    o_state.phase   = PH_HIGH;
                    o_result.vcom_setting = i_state.set_high;
                end
                PH_HIGH: begin
                    o_state.flk_high = i_item.flicker_value;
                    o_state.phase    = PH_LC;
                    o_result.vcom_setting = midpoint(i_state.set_low, i_state.set_ctr);
                end
                PH_LC: begin
                    o_state.flk_lc = i_item.flicker_value;
                    o_state.phase  = PH_RC;
                    o_result.vcom_setting = midpoint(i_state.set_ctr, i_state.set_high);
                end
                PH_RC, PH_MID: begin
                    o_state  = cont_out;
                    o_result = cont_res;
                end
                default: begin
                    o_result.status = ST_IGNORED;
                end
            endcase
        end
    end

endmodule

// ===== design/vfms_out_buf.sv =====
// Two-entry output register with skid stage for the search results.
`timescale 1ns / 1ps

module vfms_out_buf
    import vfms_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_vfms_out i_data,
    output logic      o_full,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_vfms_out o_out_data
);

`include "vcom_flicker_minimum_search_defines.svh"

    logic      r_out_valid;
    logic      n_out_valid;
    t_vfms_out r_out_data;
    t_vfms_out n_out_data;
    logic      r_skid_valid;
    logic      n_skid_valid;
    t_vfms_out r_skid_data;
    t_vfms_out n_skid_data;
    logic      pop;

    // A transfer leaves the output register when it is not stalled.
    assign pop = r_out_valid && !i_out_stall;

    // Refill from the skid stage first, then from a new result.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (pop) begin
            if (r_skid_valid) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else if (i_push) begin
                n_out_data = i_data;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid) begin
                n_out_valid = 1'b1;
                n_out_data  = i_data;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = i_data;
            end
        end
    end

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Result data.
    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The skid stage only fills behind a held output.
    `VFMS_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    // No result arrives while the skid stage is occupied.
    `VFMS_ASSERT_NOW(a_no_push_when_full, i_clk, i_rst_n, i_push, !r_skid_valid)
    // A lone result that is taken with nothing behind it leaves the buffer empty.
    `VFMS_ASSERT_NEXT(a_drain_empty, i_clk, i_rst_n,
        pop && !r_skid_valid && !i_push, !r_out_valid)

endmodule

// ===== tb/vcom_flicker_minimum_search_test.sv =====
// Self-checking testbench for the VCOM flicker minimum search sequencer.
`timescale 1ns / 1ps

module vcom_flicker_minimum_search_test;
    import vfms_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1800;
    localparam int PLAN_PHASES  = 9;
    localparam int DIRECTED_N   = 21;

    // One row of the directed stimulus; the result is typed in only where marked.
    typedef struct packed {
        t_func                fn;
        logic [FLICKER_W-1:0] flicker;
        logic                 typed;
        logic [SETTING_W-1:0] want_setting;
        t_status              want_status;
    } t_directed_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_vfms_in             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_vfms_out            o_out_data;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [SETTING_W-1:0] i_cfg_data = '0;

    // Mirror of the search state and the register settings.
    t_phase               srch_phase;
    logic [SETTING_W-1:0] set_lo, set_mid, set_hi;
    logic [FLICKER_W-1:0] flk_lo, flk_mid, flk_hi, flk_lc;
    t_cfg                 cfg_mirror;

    t_vfms_out            pending_results[$];
    int                   errors = 0;
    int                   cycles = 0;
    int                   results_taken = 0;
    bit                   quiet = 1'b0;
    logic [FLICKER_W-1:0] last_flicker = '0;

    // Receiver idling state.
    int                   hold_left = 0;
    int                   burst_left = 0;
    int                   rx_calm_left = 0;
    bit                   rx_calm = 1'b0;
    int                   next_hold_at = 500;

    // Sender idling state.
    int                   tx_calm_left = 0;
    bit                   tx_calm = 1'b0;

    // Directed rows: idle readings, a full search from reset limits, restarts.
    t_directed_row directed_rows [0:DIRECTED_N-1] = '{
        '{FN_READING, 12'd0,    1'b1, 8'd0,   ST_IGNORED},
        '{FN_READING, 12'd4095, 1'b1, 8'd0,   ST_IGNORED},
        '{FN_START,   12'd0,    1'b1, 8'd0,   ST_MEASURE},
        '{FN_READING, 12'd4095, 1'b1, 8'd127, ST_MEASURE},
        '{FN_READING, 12'd0,    1'b1, 8'd255, ST_MEASURE},
        '{FN_READING, 12'd4095, 1'b1, 8'd63,  ST_MEASURE},
        '{FN_READING, 12'd100,  1'b1, 8'd191, ST_MEASURE},
        '{FN_READING, 12'd100,  1'b0, 8'd0,   ST_MEASURE},
        '{FN_READING, 12'd2048, 1'b0, 8'd0,   ST_MEASURE},
        '{FN_READING, 12'd1,    1'b0, 8'd0,   ST_MEASURE},
        '{FN_READING, 12'd2730, 1'b0, 8'd0,   ST_MEASURE},
        '{FN_READING, 12'd1365, 1'b0, 8'd0,   ST_MEASURE},
        '{FN_READING, 12'd4095, 1'b1, 8'd0,   ST_IGNORED},
        '{FN_START,   12'd4095, 1'b1, 8'd0,   ST_MEASURE},
        '{FN_READING, 12'd7,    1'b1, 8'd127, ST_MEASURE},
        '{FN_START,   12'd2048, 1'b1, 8'd0,   ST_MEASURE},
        '{FN_READING, 12'd4095, 1'b1, 8'd127, ST_MEASURE},
        '{FN_READING, 12'd4095, 1'b1, 8'd255, ST_MEASURE},
        '{FN_READING, 12'd0,    1'b1, 8'd63,  ST_MEASURE},
        '{FN_READING, 12'd50,   1'b1, 8'd191, ST_MEASURE},
        '{FN_START,   12'd0,    1'b1, 8'd0,   ST_MEASURE}
    };

    vcom_flicker_minimum_search i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Floor of the mean of two settings.
    function automatic logic [SETTING_W-1:0] halfway(input logic [SETTING_W-1:0] a,
                                                    input logic [SETTING_W-1:0] b);
        logic [SETTING_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[SETTING_W:1];
    endfunction

    function automatic int unsigned spread(input int unsigned a, input int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic t_vfms_out make_result(input logic [SETTING_W-1:0] setting,
                                              input t_status st);
        t_vfms_out res;
        res.vcom_setting = setting;
        res.status       = st;
        return res;
    endfunction

    // Halve the bracket toward the flatter side, or report the center when narrow.
    function automatic t_vfms_out halve_or_finish();
        if (spread(set_hi, set_lo) > cfg_mirror.stop_span) begin
            if (spread(flk_lo, flk_mid) < spread(flk_mid, flk_hi)) begin
                set_hi = set_mid;
                flk_hi = flk_mid;
            end else begin
                set_lo = set_mid;
                flk_lo = flk_mid;
            end
            set_mid    = halfway(set_lo, set_hi);
            srch_phase = PH_MID;
            return make_result(set_mid, ST_MEASURE);
        end
        srch_phase = PH_IDLE;
        return make_result(set_mid, ST_DONE);
    endfunction

    // Advance the mirrored search by one accepted item and give its result.
    function automatic t_vfms_out predict_result(input t_vfms_in item);
        logic [FLICKER_W-1:0] v;
        v = item.flicker_value;
        if (item.func == FN_START) begin
            set_lo     = cfg_mirror.low_limit;
            set_hi     = cfg_mirror.high_limit;
            set_mid    = halfway(set_lo, set_hi);
            srch_phase = PH_LOW;
            return make_result(set_lo, ST_MEASURE);
        end
        case (srch_phase)
            PH_LOW: begin
                flk_lo     = v;
                srch_phase = PH_CENTER;
                return make_result(set_mid, ST_MEASURE);
            end
            PH_CENTER: begin
                flk_mid    = v;
                srch_phase = PH_HIGH;
                return make_result(set_hi, ST_MEASURE);
            end
            PH_HIGH: begin
                flk_hi     = v;
                srch_phase = PH_LC;
                return make_result(halfway(set_lo, set_mid), ST_MEASURE);
            end
            PH_LC: begin
                flk_lc     = v;
                srch_phase = PH_RC;
                return make_result(halfway(set_mid, set_hi), ST_MEASURE);
            end
            PH_RC: begin
                // First narrowing keeps the half whose inner reading is lower, the upper half on a tie.
                if (flk_lc < v) begin
                    set_hi  = set_mid;
                    flk_hi  = flk_mid;
                    flk_mid = flk_lc;
                end else begin
                    set_lo  = set_mid;
                    flk_lo  = flk_mid;
                    flk_mid = v;
                end
                set_mid = halfway(set_lo, set_hi);
                return halve_or_finish();
            end
            PH_MID: begin
                flk_mid = v;
                return halve_or_finish();
            end
            default: begin
                return make_result('0, ST_IGNORED);
            end
        endcase
    endfunction

    // Random item, mostly well-formed searches with some noise and restarts.
    function automatic t_vfms_in make_item();
        t_vfms_in item;
        int       r;
        r = $urandom_range(0, 99);
        if (srch_phase == PH_IDLE)
            item.func = (r < 8) ? FN_READING : FN_START;
        else
            item.func = (r < 3) ? FN_START : FN_READING;
        case ($urandom_range(0, 7))
            0:       item.flicker_value = '0;
            1:       item.flicker_value = '1;
            2:       item.flicker_value = last_flicker;
            3:       item.flicker_value = FLICKER_W'($urandom_range(0, 15));
            default: item.flicker_value = FLICKER_W'($urandom);
        endcase
        last_flicker = item.flicker_value;
        return item;
    endfunction

    // Compare one result transfer with the oldest expectation.
    task automatic check_result(input t_vfms_out got);
        t_vfms_out want;
        results_taken++;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result setting %0d status %0d",
                     $time, got.vcom_setting, got.status);
            errors++;
        end else begin
            want = pending_results.pop_front();
            if (got.vcom_setting !== want.vcom_setting) begin
                $display("%0t: vcom_setting expected %0d actual %0d",
                         $time, want.vcom_setting, got.vcom_setting);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
        end
    endtask

    // Offer one item, wait for its transfer, and record what should come back.
    task automatic send_item(input t_vfms_in item, input logic typed,
                             input t_vfms_out typed_result, output t_status st);
        t_vfms_out predicted;
        if (tx_calm_left == 0) begin
            tx_calm      = ($urandom_range(0, 3) == 0);
            tx_calm_left = $urandom_range(20, 80);
        end else begin
            tx_calm_left--;
        end
        if (!quiet && !tx_calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        predicted = predict_result(item);
        pending_results.push_back(typed ? typed_result : predicted);
        st = predicted.status;
    endtask

    // Stop offering and wait until every expected result has been taken.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all three registers while no item is offered.
    task automatic write_limits(input t_cfg c);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_LOW_LIMIT;
        i_cfg_data  <= c.low_limit;
        @(posedge i_clk);
        i_cfg_index <= CFG_HIGH_LIMIT;
        i_cfg_data  <= c.high_limit;
        @(posedge i_clk);
        i_cfg_index <= CFG_STOP_SPAN;
        i_cfg_data  <= c.stop_span;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_mirror  = c;
    endtask

    // Random items until the given number of results other than ignored.
    task automatic run_random(input int n);
        int       counted;
        t_status  st;
        t_vfms_in item;
        counted = 0;
        while (counted < n) begin
            item = make_item();
            send_item(item, 1'b0, '0, st);
            if (st != ST_IGNORED)
                counted++;
        end
    endtask

    // Cycle budget for the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time,
                     pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: check each transfer, then pick the next stall value.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall)
                check_result(o_out_data);
            if (quiet) begin
                i_out_stall <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (results_taken >= next_hold_at) begin
                // Long hold so the output buffer fills and the input stalls.
                hold_left    = 60;
                next_hold_at = next_hold_at + 600;
                i_out_stall <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (rx_calm_left == 0) begin
                    rx_calm      = ($urandom_range(0, 3) == 0);
                    rx_calm_left = $urandom_range(20, 80);
                end else begin
                    rx_calm_left--;
                end
                if (!rx_calm && $urandom_range(0, 3) == 0) begin
                    burst_left   = $urandom_range(0, 3);
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // Main sequence: reset, directed table, then random phases per setting.
    initial begin
        t_cfg      plan[PLAN_PHASES];
        t_vfms_in  item;
        t_status   st;
        int        p;

        srch_phase = PH_IDLE;
        set_lo     = '0;
        set_mid    = '0;
        set_hi     = '0;
        flk_lo     = '0;
        flk_mid    = '0;
        flk_hi     = '0;
        flk_lc     = '0;
        cfg_mirror.low_limit  = LOW_LIMIT_RST;
        cfg_mirror.high_limit = HIGH_LIMIT_RST;
        cfg_mirror.stop_span  = STOP_SPAN_RST;

        plan[0] = '{8'd0,   8'd255, 8'd0};
        plan[1] = '{8'd255, 8'd0,   8'd8};
        plan[2] = '{8'd77,  8'd77,  8'd0};
        plan[3] = '{8'd0,   8'd255, 8'd255};
        plan[4] = '{SETTING_W'($urandom), SETTING_W'($urandom), SETTING_W'($urandom_range(0, 40))};
        plan[5] = '{8'd255, 8'd255, 8'd255};
        plan[6] = '{SETTING_W'($urandom), SETTING_W'($urandom), SETTING_W'($urandom_range(0, 20))};
        plan[7] = '{SETTING_W'($urandom), SETTING_W'($urandom), SETTING_W'($urandom)};
        plan[8] = '{8'd3,   8'd250, 8'd1};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part runs on the reset values of the registers.
        for (int i = 0; i < DIRECTED_N; i++) begin
            item.func          = directed_rows[i].fn;
            item.flicker_value = directed_rows[i].flicker;
            send_item(item, directed_rows[i].typed,
                      make_result(directed_rows[i].want_setting,
                                  directed_rows[i].want_status), st);
        end
        drain();

        for (p = 0; p < PLAN_PHASES; p++) begin
            quiet = (p == PLAN_PHASES - 1);
            write_limits(plan[p]);
            run_random(RANDOM_ITEMS / PLAN_PHASES);
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
